/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked every clock outside reset.
`define BCP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent this cycle implies consequent next cycle.
`define BCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/bcp_pkg.sv */
package bcp_pkg;

  localparam int COORD_W = 20;
  localparam int LOC_W   = 22;   // coord +/- offset - view origin
  localparam int AXIS_W  = 16;
  localparam int PROD_W  = LOC_W + AXIS_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int CEN_W   = 13;   // half of a 14-bit screen size
  localparam int TAN_W   = 16;
  localparam int FRAC_SH = 12;   // Q4.12 tangent scale
  localparam int NUM_W   = CEN_W + DOT_W + FRAC_SH;
  localparam int DEN_W   = TAN_W + DOT_W - 1;
  localparam int Q_W     = 17;   // enough quotient bits to force saturation
  localparam int CMP_W   = DEN_W + Q_W;
  localparam int SCR_W   = 16;
  localparam int CFG_W   = 60;

  localparam logic signed [DOT_W-1:0] DEPTH_MIN = DOT_W'(1311);

  localparam logic [13:0] RST_WIDTH  = 14'd1920;
  localparam logic [13:0] RST_HEIGHT = 14'd1080;
  localparam logic [47:0] RST_RIGHT  = 48'h0000_0000_4000;
  localparam logic [47:0] RST_UP     = 48'h0000_4000_0000;
  localparam logic [47:0] RST_FWD    = 48'h4000_0000_0000;
  localparam logic [15:0] RST_TAN_X  = 16'd4096;
  localparam logic [15:0] RST_TAN_Y  = 16'd2304;

  typedef enum logic [2:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_VIEW    = 3'd2,
    CFG_RIGHT   = 3'd3,
    CFG_UP      = 3'd4,
    CFG_FORWARD = 3'd5,
    CFG_TAN_X   = 3'd6,
    CFG_TAN_Y   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic signed [COORD_W-1:0] org_z;
    logic signed [COORD_W-1:0] half_x;
    logic signed [COORD_W-1:0] half_y;
    logic signed [COORD_W-1:0] below_z;
    logic signed [COORD_W-1:0] above_z;
  } box_t;

  typedef struct packed {
    logic [2:0]              corner_index;
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
    logic                    visible;
    logic                    last_corner;
  } corner_t;

  typedef struct packed {
    logic [2:0]              k;
    logic signed [LOC_W-1:0] x;
    logic signed [LOC_W-1:0] y;
    logic signed [LOC_W-1:0] z;
  } loc_t;

  // sideband that rides along with the divider
  typedef struct packed {
    logic [2:0] corner_index;
    logic       visible;
    logic       neg_x;
    logic       neg_y;
  } div_tag_t;

endpackage

/* rtl/core/bcp_seq.sv */
`include "assert_macros.svh"

module bcp_seq
  import bcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             box_valid,
  output logic             box_stall,
  input  box_t             box,
  input  logic [CFG_W-1:0] view_origin,
  output logic             loc_valid,
  output loc_t             loc
);

  logic       busy;
  logic [2:0] k;
  box_t       box_r;
  logic       accept;

  logic signed [LOC_W-1:0] vx, vy, vz;
  logic signed [LOC_W-1:0] hx, hy, zoff;
  loc_t                    loc_next;

  assign box_stall = busy && !(adv && k == 3'd7);
  assign accept    = box_valid && !box_stall;

  assign vx = LOC_W'($signed(view_origin[COORD_W-1:0]));
  assign vy = LOC_W'($signed(view_origin[2*COORD_W-1:COORD_W]));
  assign vz = LOC_W'($signed(view_origin[3*COORD_W-1:2*COORD_W]));

  // corner order A(-,-) B(+,+) C(-,+) D(+,-); low z first, then high z
  always_comb begin
    hx   = k[0] ? LOC_W'(box_r.half_x) : -LOC_W'(box_r.half_x);
    hy   = (k[0] ^ k[1]) ? LOC_W'(box_r.half_y) : -LOC_W'(box_r.half_y);
    zoff = k[2] ? LOC_W'(box_r.above_z) : -LOC_W'(box_r.below_z);
    loc_next.k = k;
    loc_next.x = LOC_W'(box_r.org_x) + hx - vx;
    loc_next.y = LOC_W'(box_r.org_y) + hy - vy;
    loc_next.z = LOC_W'(box_r.org_z) + zoff - vz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= 3'd0;
      loc_valid <= 1'b0;
    end else begin
      if (adv) loc_valid <= busy;
      if (accept) begin
        busy <= 1'b1;
        k    <= 3'd0;
      end else if (adv && busy) begin
        k <= k + 3'd1;
        if (k == 3'd7) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) box_r <= box;
    if (adv) loc <= loc_next;
  end

  `BCP_ASSERT_NEXT(a_start_run, clk, rst, accept, busy && k == 3'd0, "box run did not start at corner 0")

endmodule

/* rtl/core/bcp_xform.sv */
module bcp_xform
  import bcp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   loc_valid,
  input  loc_t                   loc,
  input  logic [3*AXIS_W-1:0]    right_axis,
  input  logic [3*AXIS_W-1:0]    up_axis,
  input  logic [3*AXIS_W-1:0]    forward_axis,
  input  logic [CEN_W-1:0]       cx,
  input  logic [CEN_W-1:0]       cy,
  input  logic [TAN_W-1:0]       tan_x,
  input  logic [TAN_W-1:0]       tan_y,
  output logic                   div_valid,
  output div_tag_t               div_tag,
  output logic [1:0][NUM_W-1:0]  num,
  output logic [1:0][DEN_W-1:0]  den
);

  // stage A: nine products
  logic                     va;
  logic [2:0]               ka;
  logic signed [PROD_W-1:0] pr [3], pu [3], pf [3];
  // stage B: dot products
  logic                     vb;
  logic [2:0]               kb;
  logic signed [DOT_W-1:0]  r, u, d;
  // stage C: magnitudes
  logic                     vc;
  logic [2:0]               kc;
  logic [DOT_W-1:0]         rabs, uabs;
  logic [DOT_W-2:0]         dpos;
  logic                     negr, negu, visc;

  logic signed [LOC_W-1:0]  lv [3];
  logic [TAN_W-1:0]         tx_eff, ty_eff;
  logic [CEN_W+DOT_W-1:0]   nx, ny;

  assign lv[0] = loc.x;
  assign lv[1] = loc.y;
  assign lv[2] = loc.z;

  assign tx_eff = (tan_x == '0) ? TAN_W'(1) : tan_x;
  assign ty_eff = (tan_y == '0) ? TAN_W'(1) : tan_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      div_valid <= 1'b0;
    end else if (adv) begin
      va        <= loc_valid;
      vb        <= va;
      vc        <= vb;
      div_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ka <= loc.k;
      for (int i = 0; i < 3; i++) begin
        pr[i] <= lv[i] * $signed(right_axis[i*AXIS_W +: AXIS_W]);
        pu[i] <= lv[i] * $signed(up_axis[i*AXIS_W +: AXIS_W]);
        pf[i] <= lv[i] * $signed(forward_axis[i*AXIS_W +: AXIS_W]);
      end

      kb <= ka;
      r  <= DOT_W'(pr[0]) + DOT_W'(pr[1]) + DOT_W'(pr[2]);
      u  <= DOT_W'(pu[0]) + DOT_W'(pu[1]) + DOT_W'(pu[2]);
      d  <= DOT_W'(pf[0]) + DOT_W'(pf[1]) + DOT_W'(pf[2]);

      kc   <= kb;
      negr <= r[DOT_W-1];
      negu <= u[DOT_W-1];
      rabs <= r[DOT_W-1] ? (~r + 1'b1) : r;
      uabs <= u[DOT_W-1] ? (~u + 1'b1) : u;
      dpos <= d[DOT_W-2:0];
      visc <= d >= DEPTH_MIN;

      div_tag.corner_index <= kc;
      div_tag.visible      <= visc;
      div_tag.neg_x        <= negr;
      div_tag.neg_y        <= negu;
      num[0] <= {nx, {FRAC_SH{1'b0}}};
      num[1] <= {ny, {FRAC_SH{1'b0}}};
      den[0] <= {{(DOT_W-1){1'b0}}, tx_eff} * {{TAN_W{1'b0}}, dpos};
      den[1] <= {{(DOT_W-1){1'b0}}, ty_eff} * {{TAN_W{1'b0}}, dpos};
    end
  end

  assign nx = {{DOT_W{1'b0}}, cx} * {{CEN_W{1'b0}}, rabs};
  assign ny = {{DOT_W{1'b0}}, cy} * {{CEN_W{1'b0}}, uabs};

endmodule

/* rtl/core/bcp_div.sv */
module bcp_div
  import bcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  div_tag_t              in_tag,
  input  logic [1:0][NUM_W-1:0] num,
  input  logic [1:0][DEN_W-1:0] den,
  output logic                  out_valid,
  output div_tag_t              out_tag,
  output logic [1:0][Q_W-1:0]   quo,
  output logic [1:0]            ovf,
  output logic [1:0]            rem_zero
);

  logic     vs  [0:Q_W];
  div_tag_t tag [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= Q_W; j++) vs[j] <= 1'b0;
    end else if (adv) begin
      vs[0] <= in_valid;
      for (int j = 1; j <= Q_W; j++) vs[j] <= vs[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= in_tag;
      for (int j = 1; j <= Q_W; j++) tag[j] <= tag[j-1];
    end
  end

  assign out_valid = vs[Q_W];
  assign out_tag   = tag[Q_W];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [NUM_W-1:0] rem [0:Q_W];
    logic [DEN_W-1:0] dv  [0:Q_W];
    logic [Q_W-1:0]   q   [0:Q_W];
    logic             of  [0:Q_W];

    // stage 0 flags a quotient that needs more than Q_W bits
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[0] <= num[l];
        dv[0]  <= den[l];
        q[0]   <= '0;
        of[0]  <= CMP_W'(num[l]) >= {den[l], {Q_W{1'b0}}};
      end
    end

    // one restoring step per stage, MSB first
    for (genvar j = 1; j <= Q_W; j++) begin : g_step
      localparam int SH = Q_W - j;
      logic [CMP_W:0] diff;
      assign diff = {1'b0, CMP_W'(rem[j-1])} - {1'b0, CMP_W'(dv[j-1]) << SH};
      always_ff @(posedge clk) begin
        if (adv) begin
          dv[j] <= dv[j-1];
          of[j] <= of[j-1];
          if (!diff[CMP_W]) begin
            rem[j] <= diff[NUM_W-1:0];
            q[j]   <= q[j-1] | (Q_W'(1) << SH);
          end else begin
            rem[j] <= rem[j-1];
            q[j]   <= q[j-1];
          end
        end
      end
    end

    assign quo[l]      = q[Q_W];
    assign ovf[l]      = of[Q_W];
    assign rem_zero[l] = rem[Q_W] == '0;
  end

endmodule

/* rtl/core/box_corner_projection.sv */
// Box corner projector. A box beat is taken on box_valid/box_stall and
// yields eight corner beats, low A,B,C,D then high A,B,C,D, one per cycle
// unless stalled; the corner sequencer issues them into the pipeline and
// accepts a new box when idle or as it issues the last corner of the one before.
// A corner passes the loc, product, dot product, magnitude and num/den
// registers, the pipelined divider (one quotient bit per stage), then one
// output register. corner_stall freezes the whole pipeline without loss
// while corner_valid is high. Configuration is written on cfg_we and is
// read live, so write it only while no box is in flight.
`include "assert_macros.svh"

module box_corner_projection
  import bcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             box_valid,
  output logic             box_stall,
  input  box_t             box,
  output logic             corner_valid,
  input  logic             corner_stall,
  output corner_t          corner
);

  logic [13:0]         screen_width, screen_height;
  logic [CFG_W-1:0]    view_origin;
  logic [47:0]         right_axis, up_axis, forward_axis;
  logic [TAN_W-1:0]    tan_x, tan_y;
  logic [CEN_W-1:0]    cx, cy;

  logic                  adv;
  logic                  loc_valid;
  loc_t                  loc;
  logic                  div_valid;
  div_tag_t              div_tag;
  logic [1:0][NUM_W-1:0] num;
  logic [1:0][DEN_W-1:0] den;
  logic                  q_valid;
  div_tag_t              q_tag;
  logic [1:0][Q_W-1:0]   quo;
  logic [1:0]            ovf, rem_zero;
  corner_t               corner_next;

  assign cx  = screen_width[13:1];
  assign cy  = screen_height[13:1];
  assign adv = !(corner_valid && corner_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RST_WIDTH;
      screen_height <= RST_HEIGHT;
      view_origin   <= '0;
      right_axis    <= RST_RIGHT;
      up_axis       <= RST_UP;
      forward_axis  <= RST_FWD;
      tan_x         <= RST_TAN_X;
      tan_y         <= RST_TAN_Y;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:   screen_width  <= cfg_data[13:0];
        CFG_HEIGHT:  screen_height <= cfg_data[13:0];
        CFG_VIEW:    view_origin   <= cfg_data;
        CFG_RIGHT:   right_axis    <= cfg_data[47:0];
        CFG_UP:      up_axis       <= cfg_data[47:0];
        CFG_FORWARD: forward_axis  <= cfg_data[47:0];
        CFG_TAN_X:   tan_x         <= cfg_data[TAN_W-1:0];
        CFG_TAN_Y:   tan_y         <= cfg_data[TAN_W-1:0];
        default: ;
      endcase
    end
  end

  bcp_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .box_valid   (box_valid),
    .box_stall   (box_stall),
    .box         (box),
    .view_origin (view_origin),
    .loc_valid   (loc_valid),
    .loc         (loc)
  );

  bcp_xform u_xform (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .loc_valid    (loc_valid),
    .loc          (loc),
    .right_axis   (right_axis),
    .up_axis      (up_axis),
    .forward_axis (forward_axis),
    .cx           (cx),
    .cy           (cy),
    .tan_x        (tan_x),
    .tan_y        (tan_y),
    .div_valid    (div_valid),
    .div_tag      (div_tag),
    .num          (num),
    .den          (den)
  );

  bcp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_tag    (div_tag),
    .num       (num),
    .den       (den),
    .out_valid (q_valid),
    .out_tag   (q_tag),
    .quo       (quo),
    .ovf       (ovf),
    .rem_zero  (rem_zero)
  );

  // trunc(c -/+ |n|/den) toward zero, saturated; neg means the ratio is negative
  function automatic logic signed [SCR_W-1:0] screen_val(
    input logic           neg,
    input logic [CEN_W-1:0] c,
    input logic [Q_W-1:0] q,
    input logic           of,
    input logic           rz
  );
    logic [Q_W-1:0]        qq;
    logic signed [Q_W+1:0] v;
    qq = of ? '1 : q;
    if (neg) begin
      v = $signed({1'b0, (Q_W+1)'(c)}) + $signed({2'b0, qq});
    end else if (!rz && (Q_W'(c) > qq)) begin
      v = $signed({1'b0, (Q_W+1)'(c)}) - $signed({2'b0, qq}) - (Q_W+2)'(1);
    end else begin
      v = $signed({1'b0, (Q_W+1)'(c)}) - $signed({2'b0, qq});
    end
    if (v > (Q_W+2)'(32767)) begin
      screen_val = 16'sh7FFF;
    end else if (v < -(Q_W+2)'(32768)) begin
      screen_val = 16'sh8000;
    end else begin
      screen_val = v[SCR_W-1:0];
    end
  endfunction

  always_comb begin
    corner_next.corner_index = q_tag.corner_index;
    corner_next.visible      = q_tag.visible;
    corner_next.last_corner  = q_tag.corner_index == 3'd7;
    corner_next.screen_x     = '0;
    corner_next.screen_y     = '0;
    if (q_tag.visible) begin
      corner_next.screen_x = screen_val(q_tag.neg_x, cx, quo[0], ovf[0], rem_zero[0]);
      corner_next.screen_y = screen_val(q_tag.neg_y, cy, quo[1], ovf[1], rem_zero[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_valid <= 1'b0;
    end else if (adv) begin
      corner_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) corner <= corner_next;
  end

  `BCP_ASSERT(a_last_flag, clk, rst, !corner_valid || (corner.last_corner == (corner.corner_index == 3'd7)), "last_corner out of step with corner_index")
  `BCP_ASSERT(a_hidden_zero, clk, rst, !(corner_valid && !corner.visible) || (corner.screen_x == 16'sd0 && corner.screen_y == 16'sd0), "hidden corner carries a position")

endmodule

/* verif/box_corner_checker.sv */
module box_corner_checker
  import bcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             box_valid,
  input  logic             box_stall,
  input  box_t             box,
  input  logic             corner_valid,
  input  logic             corner_stall,
  input  corner_t          corner,
  output int               fails,
  output int               pending
);

  logic [13:0] scr_w, scr_h;
  logic [59:0] cam;
  logic [47:0] ax_r, ax_u, ax_f;
  logic [15:0] tan_x, tan_y;

  corner_t corners_due[$];

  function automatic longint comp(logic [47:0] v, int i);
    comp = longint'($signed(v[16*i +: 16]));
  endfunction

  function automatic longint dot(longint p[3], logic [47:0] ax);
    dot = p[0] * comp(ax, 0) + p[1] * comp(ax, 1) + p[2] * comp(ax, 2);
  endfunction

  // trunc(c - c*4096*num/(t*d)) then clamp to 16 bits
  function automatic longint screen_pos(longint c, longint num, logic [15:0] t, longint d);
    longint tt, a, b, q, rm, res;
    tt = (t == 0) ? 1 : longint'(t);
    a = c * 4096 * num;
    b = tt * d;
    q = a / b;
    rm = a % b;
    if (rm < 0) begin
      q = q - 1;
      rm = rm + b;
    end
    if (rm == 0) res = c - q;
    else begin
      res = c - q - 1;
      if (res < 0) res = res + 1;
    end
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    screen_pos = res;
  endfunction

  task automatic project_box(box_t b);
    longint vx, vy, vz, cx, cy, r, u, d;
    longint p[3];
    corner_t c;
    int sel;
    vx = longint'($signed(cam[19:0]));
    vy = longint'($signed(cam[39:20]));
    vz = longint'($signed(cam[59:40]));
    cx = longint'(scr_w >> 1);
    cy = longint'(scr_h >> 1);
    for (int k = 0; k < 8; k++) begin
      sel = k & 3;
      // A(-,-) B(+,+) C(-,+) D(+,-)
      p[0] = longint'(b.org_x) + ((sel == 1 || sel == 3) ? 1 : -1) * longint'(b.half_x) - vx;
      p[1] = longint'(b.org_y) + ((sel == 1 || sel == 2) ? 1 : -1) * longint'(b.half_y) - vy;
      p[2] = ((k < 4) ? longint'(b.org_z) - longint'(b.below_z)
                      : longint'(b.org_z) + longint'(b.above_z)) - vz;
      r = dot(p, ax_r);
      u = dot(p, ax_u);
      d = dot(p, ax_f);
      c.corner_index = 3'(k);
      c.visible = (d >= 1311);
      c.last_corner = (k == 7);
      c.screen_x = '0;
      c.screen_y = '0;
      if (c.visible) begin
        c.screen_x = 16'(screen_pos(cx, r, tan_x, d));
        c.screen_y = 16'(screen_pos(cy, u, tan_y, d));
      end
      corners_due.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    corner_t want;
    if (rst) begin
      scr_w <= RST_WIDTH;
      scr_h <= RST_HEIGHT;
      cam   <= '0;
      ax_r  <= RST_RIGHT;
      ax_u  <= RST_UP;
      ax_f  <= RST_FWD;
      tan_x <= RST_TAN_X;
      tan_y <= RST_TAN_Y;
      corners_due.delete();
      fails <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:   scr_w <= cfg_data[13:0];
          CFG_HEIGHT:  scr_h <= cfg_data[13:0];
          CFG_VIEW:    cam   <= cfg_data[59:0];
          CFG_RIGHT:   ax_r  <= cfg_data[47:0];
          CFG_UP:      ax_u  <= cfg_data[47:0];
          CFG_FORWARD: ax_f  <= cfg_data[47:0];
          CFG_TAN_X:   tan_x <= cfg_data[15:0];
          CFG_TAN_Y:   tan_y <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (box_valid && !box_stall) project_box(box);
      if (corner_valid && !corner_stall) begin
        if (corners_due.size() == 0) begin
          if (fails < 10) $display("unexpected corner beat %p", corner);
          fails <= fails + 1;
        end else begin
          want = corners_due.pop_front();
          if (corner !== want) begin
            if (fails < 10)
              $display("corner mismatch: exp %p got %p", want, corner);
            fails <= fails + 1;
          end
        end
      end
    end
    pending <= corners_due.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import bcp_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int BOX_W      = $bits(box_t);

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             box_valid;
  logic             box_stall;
  box_t             box;
  logic             corner_valid;
  logic             corner_stall;
  corner_t          corner;
  int               fails;
  int               pending;
  logic             calm;
  int               idle_cycles;

  box_corner_projection uut (.*);

  box_corner_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in bursts
  initial begin
    corner_stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        corner_stall <= 1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        corner_stall <= 0;
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (box_valid && !box_stall) || (corner_valid && !corner_stall))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // called at a posedge; returns at the posedge the beat is taken, or later after a random idle gap when calm is low
  task automatic send_box(box_t b);
    logic taken;
    box <= b;
    box_valid <= 1;
    do begin
      @(negedge clk);
      taken = !box_stall;
      @(posedge clk);
    end while (!taken);
    if (!calm && $urandom_range(0, 4) == 0) begin
      box_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain;
    box_valid <= 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic load_regs(logic [13:0] w, logic [13:0] h, logic [59:0] v,
                           logic [47:0] r, logic [47:0] u, logic [47:0] f,
                           logic [15:0] tx, logic [15:0] ty);
    logic [CFG_W-1:0] vals[8];
    vals = '{60'(w), 60'(h), v, 60'(r), 60'(u), 60'(f), 60'(tx), 60'(ty)};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic box_t mk_box(int ox, int oy, int oz, int hx, int hy, int bz, int az);
    box_t b;
    b.org_x   = COORD_W'(ox);
    b.org_y   = COORD_W'(oy);
    b.org_z   = COORD_W'(oz);
    b.half_x  = COORD_W'(hx);
    b.half_y  = COORD_W'(hy);
    b.below_z = COORD_W'(bz);
    b.above_z = COORD_W'(az);
    return b;
  endfunction

  function automatic logic [19:0] near(logic [59:0] v, int i, int span);
    near = 20'($signed(v[20*i +: 20]) + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic box_t random_box(logic [59:0] v);
    box_t b;
    if ($urandom_range(0, 3) == 0) begin
      b = box_t'(BOX_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    end else begin
      b.org_x    = near(v, 0, 3000);
      b.org_y    = near(v, 1, 3000);
      b.org_z    = near(v, 2, 3000);
      b.half_x   = 20'($urandom_range(0, 400) - 200);
      b.half_y   = 20'($urandom_range(0, 400) - 200);
      b.below_z  = 20'($urandom_range(0, 400) - 200);
      b.above_z  = 20'($urandom_range(0, 400) - 200);
    end
    return b;
  endfunction

  task automatic random_boxes(int n, logic [59:0] v);
    for (int i = 0; i < n; i++) send_box(random_box(v));
  endtask

  function automatic logic [47:0] rand_axes;
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  initial begin
    logic [59:0] cam;
    rst = 1;
    calm = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    box_valid = 0;
    box = '0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: directed boxes
    send_box('0);                                                   // at the camera
    send_box(mk_box(0, 0, 800, 100, 100, 50, 50));
    send_box(mk_box(0, 0, 1, 0, 0, 0, 0));                          // shallowest depth
    send_box(mk_box(0, 0, 1, 0, 0, 1, -2));                         // depth zero, negative
    send_box(mk_box(524287, -524288, 2, 0, 0, 0, 0));               // saturation
    send_box(mk_box(-524288, 524287, 2, 0, 0, 0, 0));
    send_box(mk_box(524287, 524287, 524287, 524287, 524287, 524287, 524287));
    send_box(mk_box(-524288, -524288, -524288, -524288, -524288, -524288, -524288));
    send_box(mk_box(-524288, -524288, -524288, 524287, 524287, 524287, 524287));
    send_box(mk_box(100, -100, 4000, -300, 250, -2000, 100000));
    send_box(mk_box(-7, 13, 50, -3, 9, -40, 0));
    drain();

    // odd width, unit height, smallest and largest tangents, permuted axes
    cam = {20'sd1000, -20'sd500, 20'sd300};
    load_regs(14'd8191, 14'd1, cam, 48'h0000_4000_0000, 48'h4000_0000_0000,
              48'h0000_0000_c000, 16'd1, 16'd65535);
    send_box(mk_box(300, -500, 1000, 10, 10, 0, 0));
    random_boxes(60, cam);
    drain();

    // zero width and zero tangents
    cam = {-20'sd2000, 20'sd7000, -20'sd9000};
    load_regs(14'd0, 14'd8192, cam, 48'hc000_0000_0000, 48'h0000_c000_0000,
              48'h0000_0000_4000, 16'd0, 16'd0);
    send_box(mk_box(-9000, 7000, -2000, 5, 5, 5, 5));
    random_boxes(60, cam);
    drain();

    // arbitrary camera and axes
    for (int p = 0; p < 2; p++) begin
      cam = {20'($urandom), 20'($urandom), 20'($urandom)};
      if (p == 1) cam = '1;
      load_regs(14'($urandom), 14'($urandom), cam, rand_axes(), rand_axes(), rand_axes(),
                16'($urandom), 16'($urandom));
      random_boxes(50, cam);
      drain();
    end

    // tilted camera, extreme viewport; the second half runs with no idling or stalls
    cam = {20'sd1, 20'sd0, 20'sd0};
    load_regs(14'd1, 14'h3fff, cam, 48'h0000_2d41_2d41, 48'h2d41_0000_d2bf,
              48'h2d41_2d41_0000, 16'd4096, 16'd2304);
    random_boxes(40, cam);
    calm = 1;
    random_boxes(40, cam);

    box_valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
